### rtl/sqell_pkg.sv
package sqell_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int REG_W = 31;
  localparam int ADDR_W = 4;
  localparam int FRAC = 30;
  localparam int Q_BITS = 31;
  localparam int ROOT_BITS = 32;
  localparam int FRONT_LAT = 4;
  localparam int SCALE_LAT = 3;

  // Normalised value for a magnitude of two semi-axes or more (2.0 in Q2.30).
  localparam logic [31:0] NORM_SAT = 32'h8000_0000;

  localparam logic [REG_W-1:0] AXIS_RESET = 31'd65536;
  localparam logic [REG_W-1:0] THR_RESET = 31'd11;

  typedef enum logic [1:0] {
    REG_A   = 2'd0,
    REG_B   = 2'd1,
    REG_THR = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic outside;
    logic centre;
  } flags_t;

endpackage

### rtl/sqell_front.sv
module sqell_front import sqell_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] start_x,
  input  logic signed [CW-1:0] start_y,
  input  logic signed [CW-1:0] start_z,
  input  logic signed [CW-1:0] finish_x,
  input  logic signed [CW-1:0] finish_y,
  input  logic signed [CW-1:0] finish_z,
  input  logic signed [31:0]   param_t,
  input  logic [REG_W-1:0]     axis_a,
  input  logic [REG_W-1:0]     axis_b,
  output logic [CW-1:0]        mag_x,
  output logic [CW-1:0]        mag_y,
  output logic                 sat_x,
  output logic                 sat_y,
  output logic [CW-1:0]        pos_z,
  output flags_t               flags
);

  localparam int HW = CW - 15;
  localparam int HPW = HW + 33;
  localparam int LPW = 48;
  localparam int SW = CW + 34;
  localparam int MW = ((CW > 32) ? CW : 32) + 1;
  localparam logic signed [32:0] T_ONE = 33'sd1073741824;
  localparam logic signed [SW-1:0] ROUND = SW'(1) <<< 30;

  logic signed [32:0]    t_ext;
  logic signed [32:0]    t_sat;
  logic signed [CW-1:0]  crd [6];
  logic [31:0]           w0;
  logic [31:0]           w1;
  logic signed [HPW-1:0] hp [6];
  logic [LPW-1:0]        lp [6];
  logic signed [CW-1:0]  pos [3];
  logic [CW-1:0]         mx;
  logic [CW-1:0]         my;

  always_comb begin
    t_ext = 33'(param_t);
    if (t_ext > T_ONE) begin
      t_sat = T_ONE;
    end else if (t_ext < -T_ONE) begin
      t_sat = -T_ONE;
    end else begin
      t_sat = t_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      crd[0] <= start_x;
      crd[1] <= start_y;
      crd[2] <= start_z;
      crd[3] <= finish_x;
      crd[4] <= finish_y;
      crd[5] <= finish_z;
      w0 <= 32'(T_ONE - t_sat);
      w1 <= 32'(T_ONE + t_sat);
    end
  end

  // Each coordinate is split into a signed high part and 16 low bits so
  // that no product is wider than about 33 by 33 bits.
  for (genvar j = 0; j < 6; j++) begin : g_mul
    logic signed [HW-1:0] hi;
    logic [15:0]          lo;
    logic [31:0]          wt;
    logic signed [32:0]   ws;
    assign hi = HW'(crd[j] >>> 16);
    assign lo = crd[j][15:0];
    assign wt = (j < 3) ? w0 : w1;
    assign ws = $signed({1'b0, wt});
    always_ff @(posedge clk) begin
      if (en) begin
        hp[j] <= hi * ws;
        lp[j] <= lo * wt;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sum
    logic signed [SW-1:0] hs;
    logic [SW-1:0]        ls;
    logic signed [SW-1:0] tot;
    assign hs = SW'(hp[k]) + SW'(hp[k+3]);
    assign ls = SW'(lp[k]) + SW'(lp[k+3]);
    assign tot = (hs <<< 16) + $signed(ls) + ROUND;
    always_ff @(posedge clk) begin
      if (en) begin
        pos[k] <= tot[CW+30:31];
      end
    end
  end

  assign mx = pos[0][CW-1] ? CW'(-pos[0]) : CW'(pos[0]);
  assign my = pos[1][CW-1] ? CW'(-pos[1]) : CW'(pos[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x <= mx;
      mag_y <= my;
      sat_x <= MW'(mx) >= MW'({axis_a, 1'b0});
      sat_y <= MW'(my) >= MW'({axis_b, 1'b0});
      pos_z <= pos[2];
      flags.neg_x <= pos[0][CW-1];
      flags.neg_y <= pos[1][CW-1];
      flags.outside <= (MW'(mx) > MW'(axis_a)) || (MW'(my) > MW'(axis_b));
      flags.centre <= 1'b0;
    end
  end

endmodule

### rtl/sqell_div.sv
module sqell_div import sqell_pkg::*; #(
  parameter int RW = 32
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RW-1:0]     dividend,
  input  logic [RW-1:0]     divisor,
  output logic [Q_BITS-1:0] quotient
);

  // Restoring division, one quotient bit per stage. The dividend enters as
  // the first partial remainder; the fraction bits shift in as zeros.
  logic [RW-1:0]     rem [Q_BITS-1];
  logic [RW-1:0]     dvs [Q_BITS-1];
  logic [Q_BITS-1:0] quo [Q_BITS];

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    logic [RW-1:0]     cand;
    logic [RW-1:0]     dv;
    logic [Q_BITS-1:0] qp;
    logic              take;
    if (i == 0) begin : g_head
      assign cand = dividend;
      assign dv = divisor;
      assign qp = '0;
    end else begin : g_body
      assign cand = {rem[i-1][RW-2:0], 1'b0};
      assign dv = dvs[i-1];
      assign qp = quo[i-1];
    end
    assign take = cand >= dv;
    always_ff @(posedge clk) begin
      if (en) begin
        quo[i] <= {qp[Q_BITS-2:0], take};
      end
    end
    if (i < Q_BITS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? cand - dv : cand;
          dvs[i] <= dv;
        end
      end
    end
  end

  assign quotient = quo[Q_BITS-1];

endmodule

### rtl/sqell_sqrt.sv
module sqell_sqrt import sqell_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2*ROOT_BITS-1:0] radicand,
  output logic [ROOT_BITS-1:0]   root
);

  localparam int RAD_W = 2 * ROOT_BITS;
  localparam int SQ_RW = ROOT_BITS + 3;

  // Digit-by-digit square root: two radicand bits enter each stage.
  logic [SQ_RW-1:0]     rem [ROOT_BITS-1];
  logic [RAD_W-1:0]     rad [ROOT_BITS-1];
  logic [ROOT_BITS-1:0] rt  [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    logic [SQ_RW-1:0]     prem;
    logic [RAD_W-1:0]     prad;
    logic [ROOT_BITS-1:0] prt;
    logic [SQ_RW-1:0]     cand;
    logic [SQ_RW-1:0]     trial;
    logic                 take;
    if (i == 0) begin : g_head
      assign prem = '0;
      assign prad = radicand;
      assign prt = '0;
    end else begin : g_body
      assign prem = rem[i-1];
      assign prad = rad[i-1];
      assign prt = rt[i-1];
    end
    assign cand = {prem[SQ_RW-3:0], prad[RAD_W-1 -: 2]};
    assign trial = SQ_RW'({prt, 2'b01});
    assign take = cand >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rt[i] <= {prt[ROOT_BITS-2:0], take};
      end
    end
    if (i < ROOT_BITS - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i] <= take ? cand - trial : cand;
          rad[i] <= {prad[RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign root = rt[ROOT_BITS-1];

endmodule

### rtl/sqell_scale.sv
module sqell_scale import sqell_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [31:0]      norm_q,
  input  logic [31:0]      norm_e,
  input  logic [FRAC:0]    ratio,
  input  logic [REG_W-1:0] axis_a,
  input  logic [REG_W-1:0] axis_b,
  input  flags_t           flags_in,
  input  logic [CW-1:0]    z_in,
  output logic [CW-1:0]    mapped_x,
  output logic [CW-1:0]    mapped_y,
  output logic [CW-1:0]    z_out,
  output flags_t           flags_out
);

  localparam int VW = ((CW > 33) ? CW : 33) + 1;
  localparam logic [VW-1:0] LIM = VW'(1) << (CW - 1);
  localparam logic [62:0] HALF = 63'd1 << (FRAC - 1);

  logic [62:0]   pq;
  logic [62:0]   pe;
  logic [62:0]   vq;
  logic [62:0]   ve;
  logic [31:0]   t1q;
  logic [31:0]   t1e;
  logic [32:0]   vx;
  logic [32:0]   vy;
  flags_t        f1;
  flags_t        f2;
  logic [CW-1:0] z1;
  logic [CW-1:0] z2;

  function automatic logic [CW-1:0] sat_sign(input logic [32:0] v, input logic neg);
    logic [VW-1:0] m;
    m = VW'(v);
    if (neg) begin
      if (m > LIM) m = LIM;
      sat_sign = CW'(-m);
    end else begin
      if (m > LIM - 1'b1) m = LIM - 1'b1;
      sat_sign = CW'(m);
    end
  endfunction

  assign pq = norm_q * ratio;
  assign pe = norm_e * ratio;
  assign vq = axis_a * t1q;
  assign ve = axis_b * t1e;

  always_ff @(posedge clk) begin
    if (en) begin
      t1q <= 32'((pq + HALF) >> FRAC);
      t1e <= 32'((pe + HALF) >> FRAC);
      f1 <= flags_in;
      z1 <= z_in;
      vx <= 33'((vq + HALF) >> FRAC);
      vy <= 33'((ve + HALF) >> FRAC);
      f2 <= f1;
      z2 <= z1;
      mapped_x <= f2.centre ? '0 : sat_sign(vx, f2.neg_x);
      mapped_y <= f2.centre ? '0 : sat_sign(vy, f2.neg_y);
      flags_out <= f2;
      z_out <= z2;
    end
  end

endmodule

### rtl/square_to_ellipse_radial_map.sv
// Throughput: one beat per cycle unless the output stalls; the longest paths
// are the per-bit steps of the 31-stage dividers and the 32-stage square root,
// plus 32x32 multiplies. A stalled output freezes the whole pipeline; nothing
// is dropped or repeated. Reset clears all valid bits and loads the semi-axes
// (1.0) and threshold (11).
module square_to_ellipse_radial_map import sqell_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int IN_W = ((6 * COORD_WIDTH + 32 + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COORD_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // start_x, start_y, start_z, finish_x, finish_y, finish_z, param_t
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // mapped_x, mapped_y, mapped_z, outside_box
  output logic [OUT_W-1:0]  m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CW = COORD_WIDTH;
  localparam int DL = ROOT_BITS + Q_BITS;
  localparam int LAT = FRONT_LAT + Q_BITS + 2 + ROOT_BITS + Q_BITS + SCALE_LAT;

  logic [REG_W-1:0] reg_a;
  logic [REG_W-1:0] reg_b;
  logic [REG_W-1:0] reg_thr;
  logic [REG_W-1:0] axis_a;
  logic [REG_W-1:0] axis_b;

  logic           adv;
  logic [LAT-1:0] vld;

  logic [CW-1:0] fr_mx;
  logic [CW-1:0] fr_my;
  logic          fr_sx;
  logic          fr_sy;
  logic [CW-1:0] fr_z;
  flags_t        fr_f;

  logic [Q_BITS-1:0] qx_quo;
  logic [Q_BITS-1:0] qy_quo;
  logic [CW-1:0]     d1_z [Q_BITS];
  flags_t            d1_f [Q_BITS];
  logic [Q_BITS-1:0] d1_sx;
  logic [Q_BITS-1:0] d1_sy;

  logic [31:0]   nq;
  logic [31:0]   ne;
  logic [31:0]   nm;
  flags_t        f35;
  logic [31:0]   q36;
  logic [31:0]   e36;
  logic [31:0]   m36;
  logic [63:0]   sq_q;
  logic [63:0]   sq_e;
  flags_t        f36;
  logic [CW-1:0] z36;
  logic [63:0]   s37;
  logic [31:0]   q37;
  logic [31:0]   e37;
  logic [31:0]   m37;
  flags_t        f37;
  logic [CW-1:0] z37;

  logic [31:0]   dq [DL];
  logic [31:0]   de [DL];
  flags_t        df [DL];
  logic [CW-1:0] dz [DL];
  logic [31:0]   dm [ROOT_BITS];

  logic [ROOT_BITS-1:0] root;
  logic [Q_BITS-1:0]    ratio;

  logic [CW-1:0] sc_mx;
  logic [CW-1:0] sc_my;
  logic [CW-1:0] sc_z;
  flags_t        sc_f;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a <= AXIS_RESET;
      reg_b <= AXIS_RESET;
      reg_thr <= THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[ADDR_W-1:2]))
        REG_A:   reg_a <= pwdata[REG_W-1:0];
        REG_B:   reg_b <= pwdata[REG_W-1:0];
        REG_THR: reg_thr <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[ADDR_W-1:2]))
      REG_A:   prdata = {1'b0, reg_a};
      REG_B:   prdata = {1'b0, reg_b};
      REG_THR: prdata = {1'b0, reg_thr};
      default: prdata = '0;
    endcase
  end

  // A zero semi-axis behaves as one LSB.
  assign axis_a = (reg_a == '0) ? REG_W'(1) : reg_a;
  assign axis_b = (reg_b == '0) ? REG_W'(1) : reg_b;

  // Pipeline control: every stage moves together unless the output beat is held.
  assign m_tvalid = vld[LAT-1];
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  sqell_front #(.CW(CW)) u_front (
    .clk      (clk),
    .en       (adv),
    .start_x  (s_tdata[0*CW +: CW]),
    .start_y  (s_tdata[1*CW +: CW]),
    .start_z  (s_tdata[2*CW +: CW]),
    .finish_x (s_tdata[3*CW +: CW]),
    .finish_y (s_tdata[4*CW +: CW]),
    .finish_z (s_tdata[5*CW +: CW]),
    .param_t  (s_tdata[6*CW +: 32]),
    .axis_a   (axis_a),
    .axis_b   (axis_b),
    .mag_x    (fr_mx),
    .mag_y    (fr_my),
    .sat_x    (fr_sx),
    .sat_y    (fr_sy),
    .pos_z    (fr_z),
    .flags    (fr_f)
  );

  // A saturated magnitude may not fit the divider; its quotient is replaced later.
  sqell_div #(.RW(32)) u_div_x (
    .clk      (clk),
    .en       (adv),
    .dividend (fr_sx ? 32'd0 : 32'(fr_mx)),
    .divisor  (32'(axis_a)),
    .quotient (qx_quo)
  );

  sqell_div #(.RW(32)) u_div_y (
    .clk      (clk),
    .en       (adv),
    .dividend (fr_sy ? 32'd0 : 32'(fr_my)),
    .divisor  (32'(axis_b)),
    .quotient (qy_quo)
  );

  assign nq = d1_sx[Q_BITS-1] ? NORM_SAT : {1'b0, qx_quo};
  assign ne = d1_sy[Q_BITS-1] ? NORM_SAT : {1'b0, qy_quo};
  assign nm = (nq > ne) ? nq : ne;

  always_comb begin
    f35 = d1_f[Q_BITS-1];
    f35.centre = ((nq < {1'b0, reg_thr}) && (ne < {1'b0, reg_thr})) || (nm == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_z[0] <= fr_z;
      d1_f[0] <= fr_f;
      d1_sx <= {d1_sx[Q_BITS-2:0], fr_sx};
      d1_sy <= {d1_sy[Q_BITS-2:0], fr_sy};
      for (int i = 1; i < Q_BITS; i++) begin
        d1_z[i] <= d1_z[i-1];
        d1_f[i] <= d1_f[i-1];
      end

      q36 <= nq;
      e36 <= ne;
      m36 <= nm;
      sq_q <= nq * nq;
      sq_e <= ne * ne;
      f36 <= f35;
      z36 <= d1_z[Q_BITS-1];

      s37 <= sq_q + sq_e;
      q37 <= q36;
      e37 <= e36;
      m37 <= m36;
      f37 <= f36;
      z37 <= z36;

      dq[0] <= q37;
      de[0] <= e37;
      df[0] <= f37;
      dz[0] <= z37;
      for (int i = 1; i < DL; i++) begin
        dq[i] <= dq[i-1];
        de[i] <= de[i-1];
        df[i] <= df[i-1];
        dz[i] <= dz[i-1];
      end
      dm[0] <= m37;
      for (int i = 1; i < ROOT_BITS; i++) begin
        dm[i] <= dm[i-1];
      end
    end
  end

  sqell_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (s37),
    .root     (root)
  );

  // m never exceeds r, so the ratio stays at or below 1.0 in Q1.30.
  sqell_div #(.RW(33)) u_div_k (
    .clk      (clk),
    .en       (adv),
    .dividend (33'(dm[ROOT_BITS-1])),
    .divisor  (33'(root)),
    .quotient (ratio)
  );

  sqell_scale #(.CW(CW)) u_scale (
    .clk       (clk),
    .en        (adv),
    .norm_q    (dq[DL-1]),
    .norm_e    (de[DL-1]),
    .ratio     (ratio),
    .axis_a    (axis_a),
    .axis_b    (axis_b),
    .flags_in  (df[DL-1]),
    .z_in      (dz[DL-1]),
    .mapped_x  (sc_mx),
    .mapped_y  (sc_my),
    .z_out     (sc_z),
    .flags_out (sc_f)
  );

  assign m_tdata = OUT_W'({sc_f.outside, sc_z, sc_my, sc_mx});

  a_hold: assert property (@(posedge clk) disable iff (rst) !adv |=> $stable(vld))
    else $error("pipeline valid bits moved during an output stall");

  a_centre: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && sc_f.centre |-> sc_mx == '0 && sc_my == '0)
    else $error("centre point produced a non-zero mapped coordinate");

  a_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !sc_f.centre && !sc_f.neg_x |-> !sc_mx[CW-1])
    else $error("mapped x sign disagrees with the interpolated point");

endmodule

### sim/sqell_checker.sv
`timescale 1ns / 1ps

module sqell_checker import sqell_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [223:0]      s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [103:0]      m_tdata,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                errors,
  output int                pending
);

  typedef struct packed {
    logic        outside;
    logic [31:0] mz;
    logic [31:0] my;
    logic [31:0] mx;
  } mapped_pt_t;

  logic [REG_W-1:0] axis_a, axis_b, centre_thr;
  mapped_pt_t mapped_q[$];

  function automatic longint lerp(longint p0, longint p1, longint w0, longint w1);
    logic signed [95:0] s0, s1, s2, acc;
    s0 = p0;
    s1 = p1;
    s2 = w0;
    acc = s0 * s2;
    s2 = w1;
    acc = acc + s1 * s2 + (96'sd1 <<< 30);
    acc = acc >>> 31;
    return longint'(acc[63:0]);
  endfunction

  function automatic logic [63:0] norm_mag(logic [63:0] mag, logic [63:0] axis);
    if (mag >= 2 * axis) return 64'd1 << 31;
    return (mag << 30) / axis;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] scale_axis(logic [63:0] qm, logic [63:0] k,
                                             logic [63:0] axis, logic neg);
    logic [63:0] t1, v;
    t1 = (qm * k + (64'd1 << 29)) >> 30;
    v = (axis * t1 + (64'd1 << 29)) >> 30;
    if (neg) begin
      if (v > (64'd1 << 31)) v = 64'd1 << 31;
      v = -v;
      return v[31:0];
    end
    if (v > (64'd1 << 31) - 1) v = (64'd1 << 31) - 1;
    return v[31:0];
  endfunction

  function automatic mapped_pt_t map_point(logic [223:0] d);
    longint t, w0, w1, px, py, pz;
    logic [63:0] a, b, xm, ym, qm, em, mm, r, k;
    mapped_pt_t res;
    t = longint'($signed(d[223:192]));
    if (t > (64'sd1 <<< 30)) t = 64'sd1 <<< 30;
    if (t < -(64'sd1 <<< 30)) t = -(64'sd1 <<< 30);
    w0 = (64'sd1 <<< 30) - t;
    w1 = (64'sd1 <<< 30) + t;
    px = lerp($signed(d[31:0]), $signed(d[127:96]), w0, w1);
    py = lerp($signed(d[63:32]), $signed(d[159:128]), w0, w1);
    pz = lerp($signed(d[95:64]), $signed(d[191:160]), w0, w1);
    a = (axis_a == 0) ? 64'd1 : 64'(axis_a);
    b = (axis_b == 0) ? 64'd1 : 64'(axis_b);
    xm = px < 0 ? -px : px;
    ym = py < 0 ? -py : py;
    qm = norm_mag(xm, a);
    em = norm_mag(ym, b);
    mm = qm > em ? qm : em;
    res = '0;
    if (!(qm < centre_thr && em < centre_thr) && mm != 0) begin
      r = int_sqrt(qm * qm + em * em);
      k = (mm << 30) / r;
      res.mx = scale_axis(qm, k, a, px < 0);
      res.my = scale_axis(em, k, b, py < 0);
    end
    res.mz = pz[31:0];
    res.outside = (xm > a) || (ym > b);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
    errors++;
  endtask

  assign pending = mapped_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    mapped_pt_t want, got;
    if (rst) begin
      axis_a <= AXIS_RESET;
      axis_b <= AXIS_RESET;
      centre_thr <= THR_RESET;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_A:   axis_a <= pwdata[REG_W-1:0];
          REG_B:   axis_b <= pwdata[REG_W-1:0];
          REG_THR: centre_thr <= pwdata[REG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) mapped_q.push_back(map_point(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[96:0];
        if (mapped_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          want = mapped_q.pop_front();
          if (got.mx !== want.mx) report("mapped_x", want.mx, got.mx);
          if (got.my !== want.my) report("mapped_y", want.my, got.my);
          if (got.mz !== want.mz) report("mapped_z", want.mz, got.mz);
          if (got.outside !== want.outside) report("outside_box", want.outside, got.outside);
        end
      end
    end
  end

endmodule

### sim/tb_square_to_ellipse_radial_map.sv
`timescale 1ns / 1ps

module tb_square_to_ellipse_radial_map import sqell_pkg::*;;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 120;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [223:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [103:0] m_tdata;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int errors, pending;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0, stall_left = 0;
  longint cur_a = 65536, cur_b = 65536;

  always #5 clk = ~clk;

  square_to_ellipse_radial_map u_dut (.*);

  sqell_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: always ready, coin toss, or mostly stalled, in stretches.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(5, 80);
    end
    stall_left--;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  function automatic logic [223:0] pack_seg(longint sx, longint sy, longint sz,
                                            longint fx, longint fy, longint fz,
                                            longint t);
    return {t[31:0], fz[31:0], fy[31:0], fx[31:0], sz[31:0], sy[31:0], sx[31:0]};
  endfunction

  // A coordinate near the box for the given semi-axis, or any value at all.
  function automatic longint rand_coord(longint axis);
    longint span, v;
    if ($urandom_range(0, 4) == 0) return longint'($signed($urandom));
    span = 2 * axis;
    if (span > 64'sd2147483647) span = 64'sd2147483647;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic longint rand_t();
    case ($urandom_range(0, 7))
      0: return longint'($signed($urandom));
      1: return 64'sd1 <<< 30;
      2: return -(64'sd1 <<< 30);
      default: return longint'($urandom_range(0, 32'h8000_0000)) - (64'sd1 <<< 30);
    endcase
  endfunction

  task automatic send_beat(logic [223:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] a, logic [31:0] b, logic [31:0] thr);
    settle();
    apb_write(ADDR_W'(4 * REG_A), a);
    apb_write(ADDR_W'(4 * REG_B), b);
    apb_write(ADDR_W'(4 * REG_THR), thr);
    cur_a = (a[30:0] == 0) ? 1 : a[30:0];
    cur_b = (b[30:0] == 0) ? 1 : b[30:0];
  endtask

  task automatic random_run(int n);
    longint sx, sy, fx, fy;
    repeat (n) begin
      sx = rand_coord(cur_a);
      sy = rand_coord(cur_b);
      fx = rand_coord(cur_a);
      fy = rand_coord(cur_b);
      send_beat(pack_seg(sx, sy, longint'($signed($urandom)), fx, fy,
                         longint'($signed($urandom)), rand_t()));
    end
  endtask

  initial begin
    longint mx, mn, one;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    one = 64'sd1 <<< 30;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: extremes, t at and beyond its ends, centre, box edges.
    send_beat(pack_seg(0, 0, 0, 0, 0, 0, 0));
    send_beat(pack_seg(mx, mx, mx, mx, mx, mx, one));
    send_beat(pack_seg(mn, mn, mn, mn, mn, mn, -one));
    send_beat(pack_seg(mn, mx, mn, mx, mn, mx, 0));
    send_beat(pack_seg(mx, mn, 7, mn, mx, -7, mx));
    send_beat(pack_seg(mx, mn, 7, mn, mx, -7, mn));
    send_beat(pack_seg(65536, 65536, 1, 65536, 65536, 1, 0));
    send_beat(pack_seg(-65536, 32768, 0, -65536, 32768, 0, 0));
    send_beat(pack_seg(65537, 0, 0, 65537, 0, 0, 0));
    send_beat(pack_seg(0, -65537, 0, 0, -65537, 0, 0));
    send_beat(pack_seg(131072, -131072, 0, 131072, -131072, 0, one));
    send_beat(pack_seg(1, 0, 0, 1, 0, 0, 0));
    send_beat(pack_seg(0, 1, 0, -1, 0, 0, 0));
    send_beat(pack_seg(-1, -1, -1, 0, 0, 0, one + 1));
    send_beat(pack_seg(3, -3, 3, 3, -3, 3, -one - 1));
    send_beat(pack_seg(-40000, 50000, 5, 40000, -50000, -5, one / 3));
    send_beat(pack_seg(mx, 0, 0, 0, mx, 0, 0));
    send_beat(pack_seg(1, 1, 1, 1, 1, 1, 1));
    random_run(270);
    // Extreme axes, zero threshold, and a write outside the register map.
    configure(32'hFFFF_FFFF, 32'd1, 32'd0);
    apb_write(4'd12, 32'h1234_5678);
    send_beat(pack_seg(0, 0, 0, 0, 0, 0, 0));
    send_beat(pack_seg(1, 0, 0, 1, 0, 0, 0));
    random_run(270);
    // Zero axes count as one LSB; the threshold at 1.0 in Q2.30.
    configure(32'd0, 32'd0, 32'h4000_0000);
    send_beat(pack_seg(0, 1, 0, 0, 1, 0, 0));
    random_run(270);
    configure(32'd3 << 16, 32'd1 << 15, 32'd1 << 20);
    random_run(270);
    configure($urandom, $urandom_range(1, 32'h0100_0000), $urandom_range(0, 32'h4000_0000));
    random_run(270);
    settle();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
